// File: design/nsf_pkg.sv
// Shared types and constants of the non-overlapping substring finder.
package nsf_pkg;

    localparam int PATTERN_MAX_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;

    // Pattern bytes with a register behind them; higher ones compare as zero
    localparam int PAT_REG_BYTES = 16;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int LEN_REG_W  = 5;
    localparam int FIELD_W    = 16;

    // Register indexes (byte address / 8)
    localparam logic [1:0] REG_PAT_LO = 2'd0;
    localparam logic [1:0] REG_PAT_HI = 2'd1;
    localparam logic [1:0] REG_LEN    = 2'd2;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pat_lo;
        logic [CFG_DATA_W-1:0] pat_hi;
        logic [LEN_REG_W-1:0]  len;
    } t_cfg;

    // One classified text byte, as handed from front to back
    typedef struct packed {
        logic               hit;
        logic               fin;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] tally;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// File: design/nsf_if.sv
// Request channels of the substring finder: text bytes in, results out.
interface nsf_in_if;
    logic valid;
    logic ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface nsf_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] match_start;
    logic [15:0] total_matches;
    logic        run_end;

    modport source (output valid, output result_kind, output match_start,
                    output total_matches, output run_end, input ready);
    modport sink   (input valid, input result_kind, input match_start,
                    input total_matches, input run_end, output ready);
endinterface

// File: design/nsf_cfg.sv
// APB-style register file holding the pattern and its length.
module nsf_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [nsf_pkg::CFG_ADDR_W-1:0]    i_paddr,
    input  logic [nsf_pkg::CFG_DATA_W-1:0]    i_pwdata,
    output logic [nsf_pkg::CFG_DATA_W-1:0]    o_prdata,
    output logic                              o_pready,
    output nsf_pkg::t_cfg                     o_cfg
);

    nsf_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign reg_idx  = i_paddr[4:3];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_lo <= '0;
            r_cfg.pat_hi <= '0;
            r_cfg.len    <= nsf_pkg::LEN_REG_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                nsf_pkg::REG_PAT_LO: r_cfg.pat_lo <= i_pwdata;
                nsf_pkg::REG_PAT_HI: r_cfg.pat_hi <= i_pwdata;
                nsf_pkg::REG_LEN:    r_cfg.len    <= i_pwdata[nsf_pkg::LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            nsf_pkg::REG_PAT_LO: o_prdata = r_cfg.pat_lo;
            nsf_pkg::REG_PAT_HI: o_prdata = r_cfg.pat_hi;
            nsf_pkg::REG_LEN:    o_prdata = nsf_pkg::CFG_DATA_W'(r_cfg.len);
            default:             o_prdata = '0;
        endcase
    end

endmodule

// File: design/nsf_front.sv
// Front end: byte window, parallel pattern compare, position and tally tracking.
module nsf_front #(
    parameter int PATTERN_MAX   = nsf_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = nsf_pkg::POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nsf_in_if.sink            i_in,
    input  nsf_pkg::t_cfg     i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output nsf_pkg::t_entry   o_entry
);

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SEEN_W = POSITION_BITS + 1;

    nsf_pkg::t_byte r_win [PATTERN_MAX];
    logic [SEEN_W-1:0]           r_seen;
    logic [SEEN_W-1:0]           r_earliest;
    logic [nsf_pkg::FIELD_W-1:0] r_tally;

    nsf_pkg::t_byte n_win [PATTERN_MAX];
    nsf_pkg::t_byte pat   [PATTERN_MAX];
    logic [SEEN_W-1:0]           n_seen;
    logic [SEEN_W-1:0]           start;
    logic [nsf_pkg::FIELD_W-1:0] n_tally;
    logic [LEN_W-1:0]            act_len;
    logic [PATTERN_MAX-1:0]      eq_ok;
    logic                        sat;
    logic                        hit;
    logic                        accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    // Length 0 acts as 1, anything above the window acts as the window size
    always_comb begin
        if (i_cfg.len == '0) begin
            act_len = LEN_W'(1);
        end else if (32'(i_cfg.len) > PATTERN_MAX) begin
            act_len = LEN_W'(PATTERN_MAX);
        end else begin
            act_len = LEN_W'(i_cfg.len);
        end
    end

    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (j < 8) begin
                pat[j] = i_cfg.pat_lo[8*(j%8) +: 8];
            end else if (j < nsf_pkg::PAT_REG_BYTES) begin
                pat[j] = i_cfg.pat_hi[8*(j%8) +: 8];
            end else begin
                pat[j] = '0;
            end
        end
    end

    always_comb begin
        n_win[0] = i_in.text_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    // window slot k (newest first) lines up with pattern byte len-1-k
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (k < int'(act_len)) begin
                eq_ok[k] = (n_win[k] == pat[IDX_W'(int'(act_len) - 1 - k)]);
            end else begin
                eq_ok[k] = 1'b1;
            end
        end
    end

    assign sat    = r_seen[POSITION_BITS];
    assign n_seen = sat ? r_seen : r_seen + SEEN_W'(1);
    assign start  = n_seen - SEEN_W'(act_len);
    assign hit    = !sat && (n_seen >= SEEN_W'(act_len)) && (start >= r_earliest)
                    && (&eq_ok);
    assign n_tally = (hit && (r_tally != '1)) ? r_tally + nsf_pkg::FIELD_W'(1) : r_tally;

    assign o_push        = accept && (hit || i_in.final_byte);
    assign o_entry.hit   = hit;
    assign o_entry.fin   = i_in.final_byte;
    assign o_entry.start = nsf_pkg::FIELD_W'(start);
    assign o_entry.tally = n_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_win[k] <= '0;
            end
            r_seen     <= '0;
            r_earliest <= '0;
            r_tally    <= '0;
        end else if (accept) begin
            if (i_in.final_byte) begin
                for (int k = 0; k < PATTERN_MAX; k++) begin
                    r_win[k] <= '0;
                end
                r_seen     <= '0;
                r_earliest <= '0;
                r_tally    <= '0;
            end else begin
                for (int k = 0; k < PATTERN_MAX; k++) begin
                    r_win[k] <= n_win[k];
                end
                r_seen  <= n_seen;
                r_tally <= n_tally;
                if (hit) begin
                    r_earliest <= n_seen;
                end
            end
        end
    end

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.final_byte) |=> (r_seen == '0 && r_tally == '0))
        else $error("stream state not cleared after final byte");

    a_earliest_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_earliest <= r_seen)
        else $error("earliest allowed start ahead of byte count");

endmodule

// File: design/nsf_queue.sv
// Short queue of classified bytes between front and back.
module nsf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nsf_pkg::t_q_ctrl  i_ctrl,
    input  nsf_pkg::t_entry   i_entry,
    output nsf_pkg::t_entry   o_head,
    output nsf_pkg::t_q_stat  o_stat
);

    nsf_pkg::t_entry r_mem [nsf_pkg::QDEPTH];
    logic [nsf_pkg::QPTR_W-1:0] r_wp;
    logic [nsf_pkg::QPTR_W-1:0] r_rp;
    logic [nsf_pkg::QCNT_W-1:0] r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == nsf_pkg::QCNT_W'(nsf_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_wp <= (r_wp == nsf_pkg::QPTR_W'(nsf_pkg::QDEPTH - 1)) ? '0
                                                                         : r_wp + 1'b1;
            end
            if (i_ctrl.pop) begin
                r_rp <= (r_rp == nsf_pkg::QPTR_W'(nsf_pkg::QDEPTH - 1)) ? '0
                                                                         : r_rp + 1'b1;
            end
            case ({i_ctrl.push, i_ctrl.pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.push && o_stat.full && !i_ctrl.pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.pop && o_stat.empty))
        else $error("pop from empty queue");

endmodule

// File: design/nsf_back.sv
// Back end: turns queued entries into match and summary results.
module nsf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nsf_pkg::t_entry   i_head,
    input  nsf_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    nsf_out_if.source         o_out
);

    logic                        r_valid;
    logic                        r_kind;
    logic [nsf_pkg::FIELD_W-1:0] r_start;
    logic [nsf_pkg::FIELD_W-1:0] r_total;
    logic                        r_last;
    logic                        r_second;   // match sent, summary of same entry pending

    logic load;
    logic emit_match;

    assign load       = (!r_valid || o_out.ready) && !i_q_stat.empty;
    assign emit_match = i_head.hit && !r_second;
    assign o_pop      = load && !(emit_match && i_head.fin);

    assign o_out.valid         = r_valid;
    assign o_out.result_kind   = r_kind;
    assign o_out.match_start   = r_start;
    assign o_out.total_matches = r_total;
    assign o_out.run_end       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b1;
            r_second <= emit_match && i_head.fin;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_total <= i_head.tally;
            if (emit_match) begin
                r_kind  <= nsf_pkg::KIND_MATCH;
                r_start <= i_head.start;
                r_last  <= !i_head.fin;
            end else begin
                r_kind  <= nsf_pkg::KIND_SUMMARY;
                r_start <= '0;
                r_last  <= 1'b1;
            end
        end
    end

    a_second_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (!i_q_stat.empty && i_head.hit && i_head.fin))
        else $error("pending summary without its queue entry");

endmodule

// File: design/nonoverlap_substring_finder.sv
// Top level of the non-overlapping substring finder.
// Text bytes stream in on i_in, one per cycle while the queue has room; the
// window of the last PATTERN_MAX bytes is compared in parallel with the pattern
// in the front end, so every byte is classified in the cycle it is accepted.
// Bytes that end a reported match or carry the final flag go into a four-entry
// queue; the back end drains it into a registered output, one result per cycle
// while the output is ready, and each result passes through a queue entry and
// then the output register. A match on the final byte gives two results (match,
// then summary) from a single queue entry; input stalls while the queue is full,
// which takes output back-pressure or a run of final bytes that each end a match.
// Registers sit at byte addresses 0, 8 and 16 on the 64-bit APB port and
// should be written while no text is in flight.
module nonoverlap_substring_finder #(
    parameter int PATTERN_MAX   = nsf_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = nsf_pkg::POSITION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    nsf_in_if.sink                          i_in,
    nsf_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nsf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [nsf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [nsf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    nsf_pkg::t_cfg    cfg;
    nsf_pkg::t_entry  entry;
    nsf_pkg::t_entry  head;
    nsf_pkg::t_q_ctrl q_ctrl;
    nsf_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    nsf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    nsf_front #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (cfg),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_entry  (entry)
    );

    nsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_entry (entry),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    nsf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
